@@ design/hpt_pkg.sv @@
package hpt_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [3:0] HALF_ONE = 4'b0011;
  localparam logic [3:0] HALF_TWO = 4'b1100;
  localparam logic [2:0] MSG_MAX = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/hpt_if.sv @@
interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] station_key;
  logic [2:0]  message_number;
  logic [31:0] time_ms;

  modport source (output valid, output station_key, output message_number,
                  output time_ms, input ready);
  modport sink (input valid, input station_key, input message_number,
                input time_ms, output ready);
endinterface

interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic        rejected;
  logic        captured;
  logic [2:0]  entry_index;
  logic [3:0]  message_mask;
  logic [31:0] capture_total;

  modport source (output valid, output rejected, output captured,
                  output entry_index, output message_mask, output capture_total,
                  input ready);
  modport sink (input valid, input rejected, input captured,
                input entry_index, input message_mask, input capture_total,
                output ready);
endinterface

@@ design/handshake_progress_tracker.sv @@
// Tracks four-message key exchanges per station key in a table of
// hpt_pkg::ENTRIES entries. Each accepted transfer is captured, then a
// sequential scan over every entry looks for the key, a free entry and the
// entry with the smallest last-seen time, and a commit updates the table and
// loads the result register once an untaken result no longer holds it. A
// rejected message number skips the scan: after capture, the scan state sees
// the rejection, then the result load follows. The result register lets the next
// item be accepted while a finished result still waits.
module handshake_progress_tracker (
  input logic      clk,
  input logic      rst_n,
  hpt_in_if.sink   in_ch,
  hpt_out_if.source out_ch
);
  import hpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hpt_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_station_key    (in_ch.station_key),
    .in_message_number (in_ch.message_number),
    .in_time_ms        (in_ch.time_ms),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_rejected      (out_ch.rejected),
    .out_captured      (out_ch.captured),
    .out_entry_index   (out_ch.entry_index),
    .out_message_mask  (out_ch.message_mask),
    .out_capture_total (out_ch.capture_total)
  );

endmodule

@@ design/hpt_ctrl.sv @@
module hpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hpt_pkg::dp_status_t status,
  output hpt_pkg::dp_cmd_t   cmd
);
  import hpt_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.reject) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (status.scan_last) begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/hpt_datapath.sv @@
module hpt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        in_station_key,
  input  logic [2:0]         in_message_number,
  input  logic [31:0]        in_time_ms,
  input  hpt_pkg::dp_cmd_t   cmd,
  output hpt_pkg::dp_status_t status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_rejected,
  output logic               out_captured,
  output logic [2:0]         out_entry_index,
  output logic [3:0]         out_message_mask,
  output logic [31:0]        out_capture_total
);
  import hpt_pkg::*;

  logic [ENTRIES-1:0] valid_r;
  logic [31:0]        key_r [ENTRIES];
  logic [3:0]         mask_r [ENTRIES];
  logic [31:0]        seen_r [ENTRIES];
  logic [ENTRIES-1:0] counted_r;
  logic [31:0]        count_r;

  logic [31:0] cur_key_r;
  logic [2:0]  cur_msg_r;
  logic [31:0] cur_time_r;
  logic        cur_reject_r;

  idx_t        scan_idx_r;
  logic        hit_r;
  idx_t        hit_idx_r;
  logic        free_r;
  idx_t        free_idx_r;
  idx_t        min_idx_r;
  logic [31:0] min_time_r;

  logic        out_valid_r;
  logic        out_rejected_r;
  logic        out_captured_r;
  logic [2:0]  out_index_r;
  logic [3:0]  out_mask_r;

  logic        scan_valid;
  logic        scan_match;
  idx_t        sel_idx;
  logic [3:0]  msg_bit;
  logic [3:0]  new_mask;
  logic        old_counted;
  logic        cap;
  logic [IDX_W+2:0] sel_wide;

  assign scan_valid = valid_r[scan_idx_r];
  assign scan_match = scan_valid && (key_r[scan_idx_r] == cur_key_r);

  always_comb begin
    priority if (hit_r) begin
      sel_idx = hit_idx_r;
    end else if (free_r) begin
      sel_idx = free_idx_r;
    end else begin
      sel_idx = min_idx_r;
    end
  end

  assign msg_bit     = 4'b0001 << (cur_msg_r - 3'd1);
  assign new_mask    = (hit_r ? mask_r[sel_idx] : 4'b0000) | msg_bit;
  assign old_counted = hit_r && counted_r[sel_idx];
  assign cap         = !old_counted && ((new_mask & HALF_ONE) != 4'b0000) &&
                       ((new_mask & HALF_TWO) != 4'b0000);
  assign sel_wide    = {3'b000, sel_idx};

  assign status.reject    = cur_reject_r;
  assign status.scan_last = (scan_idx_r == IDX_W'(ENTRIES - 1));
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_key_r    <= in_station_key;
      cur_msg_r    <= in_message_number;
      cur_time_r   <= in_time_ms;
      cur_reject_r <= (in_message_number == 3'd0) || (in_message_number > MSG_MAX);
      scan_idx_r   <= '0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      if (scan_match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= scan_idx_r;
      end
      if (!scan_valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= scan_idx_r;
      end
      if ((scan_idx_r == '0) || (seen_r[scan_idx_r] < min_time_r)) begin
        min_idx_r  <= scan_idx_r;
        min_time_r <= seen_r[scan_idx_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.commit && !cur_reject_r) begin
      valid_r[sel_idx] <= 1'b1;
      if (cap) begin
        count_r <= count_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !cur_reject_r) begin
      key_r[sel_idx]     <= cur_key_r;
      mask_r[sel_idx]    <= new_mask;
      seen_r[sel_idx]    <= cur_time_r;
      counted_r[sel_idx] <= old_counted || cap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cur_reject_r) begin
        out_rejected_r <= 1'b1;
        out_captured_r <= 1'b0;
        out_index_r    <= 3'd0;
        out_mask_r     <= 4'd0;
      end else begin
        out_rejected_r <= 1'b0;
        out_captured_r <= cap;
        out_index_r    <= sel_wide[2:0];
        out_mask_r     <= new_mask;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rejected      = out_rejected_r;
  assign out_captured      = out_captured_r;
  assign out_entry_index   = out_index_r;
  assign out_message_mask  = out_mask_r;
  assign out_capture_total = count_r;

endmodule

@@ design/hpt_checker.sv @@
module hpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_rejected,
  input logic        out_captured,
  input logic [2:0]  out_entry_index,
  input logic [3:0]  out_message_mask,
  input logic [31:0] out_capture_total
);
  import hpt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_message_mask) &&
      $stable(out_captured) && $stable(out_capture_total)))
    else $error("Result changed while stalled.");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> (!out_captured && (out_entry_index == 3'd0) &&
      (out_message_mask == 4'd0)))
    else $error("Rejected result carries entry data.");

  a_capture_halves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_captured) |-> (((out_message_mask & HALF_ONE) != 4'd0) &&
      ((out_message_mask & HALF_TWO) != 4'd0) && (out_capture_total != 32'd0)))
    else $error("Capture flagged without both halves.");

  a_mask_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rejected) |-> (out_message_mask != 4'd0))
    else $error("Accepted message left an empty mask.");

endmodule

bind handshake_progress_tracker hpt_checker u_hpt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_rejected      (out_ch.rejected),
  .out_captured      (out_ch.captured),
  .out_entry_index   (out_ch.entry_index),
  .out_message_mask  (out_ch.message_mask),
  .out_capture_total (out_ch.capture_total)
);
